### hw/rtl/go_back_n_arq_endpoint_top_defines.svh
// assertion macros for the go-back-n endpoint
// used by go_back_n_arq_endpoint_top, expects clk and rst_n in scope
`ifndef GO_BACK_N_ARQ_ENDPOINT_TOP_DEFINES_SVH
`define GO_BACK_N_ARQ_ENDPOINT_TOP_DEFINES_SVH

// same-cycle implication
`define GBN_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GBN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/gbn_arq_pkg.sv
// shared types and constants for the go-back-n endpoint
// no dependencies
package gbn_arq_pkg;

  localparam int DEF_WINDOW_DEPTH = 8;
  localparam int DEF_PAYLOAD_BITS = 32;
  localparam int DEF_SEQ_BITS     = 16;

  localparam int SEQ_PORT_W = 16;
  localparam int PAY_PORT_W = 32;
  localparam int TICK_W     = 32;
  localparam int TIMEOUT_W  = 8;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 8'd5;

  typedef enum logic [1:0] {
    FUNC_SEND = 2'd0,
    FUNC_LINK = 2'd1,
    FUNC_TICK = 2'd2,
    FUNC_NONE = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    KIND_DATA   = 2'd0,
    KIND_ACK    = 2'd1,
    KIND_REFUSE = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEND,
    ST_DATA,
    ST_ACK,
    ST_WALK,
    ST_TICK,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_RS_RD,
    ST_RS_EMIT
  } st_t;

endpackage

### hw/rtl/go_back_n_arq_endpoint_top.sv
// go-back-n arq endpoint: sender window, receiver ack logic, tick driven resend
// depends on gbn_arq_pkg and go_back_n_arq_endpoint_top_defines.svh
//
//  channel | ports                                         | direction
//  in      | in_valid in_ready in_func in_seq in_is_ack    | item in
//          | in_payload                                    |
//  out     | out_valid out_ready out_kind out_seq          | item out
//          | out_payload out_last                          |
//  cfg     | cfg_valid cfg_ready cfg_data                  | timeout write
//
// send and received data items: taken in idle, then emitted once the output register is free
// received ack: taken in idle, range checked in the ack state, then the walk state moves the base one step at a time
// tick: taken in idle, then each slot scanned for age needs a read and a check state, and each packet
//   resent a read and an emit state; the single registered read port of the slot memories sets this split
// reset is synchronous, active low; the slot memories are not cleared
// an item can be taken while a result still waits in the output register
`include "go_back_n_arq_endpoint_top_defines.svh"

module go_back_n_arq_endpoint_top #(
  parameter int WINDOW_DEPTH = gbn_arq_pkg::DEF_WINDOW_DEPTH,
  parameter int PAYLOAD_BITS = gbn_arq_pkg::DEF_PAYLOAD_BITS,
  parameter int SEQ_BITS     = gbn_arq_pkg::DEF_SEQ_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [1:0]                           in_func,
  input  logic [gbn_arq_pkg::SEQ_PORT_W-1:0]   in_seq,
  input  logic                                 in_is_ack,
  input  logic [gbn_arq_pkg::PAY_PORT_W-1:0]   in_payload,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [1:0]                           out_kind,
  output logic [gbn_arq_pkg::SEQ_PORT_W-1:0]   out_seq,
  output logic [gbn_arq_pkg::PAY_PORT_W-1:0]   out_payload,
  output logic                                 out_last,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [gbn_arq_pkg::TIMEOUT_W-1:0]    cfg_data
);

  localparam int SLOT_BITS = $clog2(WINDOW_DEPTH);
  localparam longint unsigned SEQ_MAX = (64'd1 << SEQ_BITS) - 64'd1;
  localparam longint unsigned WIN_LIMIT =
    (longint'(WINDOW_DEPTH) < SEQ_MAX) ? longint'(WINDOW_DEPTH) : SEQ_MAX;
  localparam int CNT_BITS = $clog2(WIN_LIMIT + 1);
  localparam logic [SEQ_BITS-1:0]  LIMIT_SEQ = SEQ_BITS'(WIN_LIMIT);
  localparam logic [SLOT_BITS-1:0] SLOT_LAST = SLOT_BITS'(WINDOW_DEPTH - 1);
  localparam int TW = gbn_arq_pkg::TICK_W;
  localparam int SW = gbn_arq_pkg::SEQ_PORT_W;
  localparam int PW = gbn_arq_pkg::PAY_PORT_W;

  gbn_arq_pkg::st_t st_r, st_nxt;

  logic [SEQ_BITS-1:0]     base_r, base_nxt, next_r, next_nxt, exp_r, exp_nxt;
  logic [SLOT_BITS-1:0]    base_slot_r, base_slot_nxt, next_slot_r, next_slot_nxt;
  logic [SEQ_BITS-1:0]     cur_r, cur_nxt, seq_r, seq_nxt;
  logic [SLOT_BITS-1:0]    cur_slot_r, cur_slot_nxt;
  logic [CNT_BITS-1:0]     rem_r, rem_nxt;
  logic [TW-1:0]           tick_r, tick_nxt;
  logic [gbn_arq_pkg::TIMEOUT_W-1:0] timeout_r;
  logic [PAYLOAD_BITS-1:0] pay_r, pay_nxt;

  logic                    out_valid_r, out_valid_nxt, out_last_r, out_last_nxt;
  gbn_arq_pkg::kind_t      out_kind_r, out_kind_nxt;
  logic [SW-1:0]           out_seq_r, out_seq_nxt;
  logic [PW-1:0]           out_pay_r, out_pay_nxt;

  logic [PAYLOAD_BITS-1:0] pay_mem [WINDOW_DEPTH];
  logic [TW-1:0]           stamp_mem [WINDOW_DEPTH];
  logic [PAYLOAD_BITS-1:0] pay_rd_r;
  logic [TW-1:0]           stamp_rd_r;
  logic                    pay_we, stamp_we;
  logic [SLOT_BITS-1:0]    wr_slot;

  logic [SEQ_BITS-1:0]     outstanding, adv_seq_in, adv_seq_out;
  logic [SLOT_BITS-1:0]    adv_slot_in, adv_slot_out;
  logic                    out_free, expired;

  assign outstanding = next_r - base_r;
  assign out_free    = !out_valid_r || out_ready;
  assign expired     = (tick_r - stamp_rd_r) >= {{(TW - gbn_arq_pkg::TIMEOUT_W){1'b0}}, timeout_r};

  // shared sequence/slot step unit
  always_comb begin
    case (st_r)
      gbn_arq_pkg::ST_SEND: begin
        adv_seq_in  = next_r;
        adv_slot_in = next_slot_r;
      end
      gbn_arq_pkg::ST_WALK: begin
        adv_seq_in  = base_r;
        adv_slot_in = base_slot_r;
      end
      default: begin
        adv_seq_in  = cur_r;
        adv_slot_in = cur_slot_r;
      end
    endcase
    adv_seq_out = adv_seq_in + SEQ_BITS'(1);
    if (adv_seq_out == '0 || adv_slot_in == SLOT_LAST) begin
      adv_slot_out = '0;
    end else begin
      adv_slot_out = adv_slot_in + SLOT_BITS'(1);
    end
  end

  always_comb begin
    st_nxt        = st_r;
    base_nxt      = base_r;
    base_slot_nxt = base_slot_r;
    next_nxt      = next_r;
    next_slot_nxt = next_slot_r;
    exp_nxt       = exp_r;
    cur_nxt       = cur_r;
    cur_slot_nxt  = cur_slot_r;
    rem_nxt       = rem_r;
    tick_nxt      = tick_r;
    seq_nxt       = seq_r;
    pay_nxt       = pay_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_kind_nxt  = out_kind_r;
    out_seq_nxt   = out_seq_r;
    out_pay_nxt   = out_pay_r;
    out_last_nxt  = out_last_r;
    pay_we        = 1'b0;
    stamp_we      = 1'b0;
    wr_slot       = next_slot_r;
    in_ready      = 1'b0;

    case (st_r)
      gbn_arq_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          seq_nxt = SEQ_BITS'(in_seq);
          pay_nxt = PAYLOAD_BITS'(in_payload);
          case (gbn_arq_pkg::func_t'(in_func))
            gbn_arq_pkg::FUNC_SEND: st_nxt = gbn_arq_pkg::ST_SEND;
            gbn_arq_pkg::FUNC_LINK: begin
              st_nxt = in_is_ack ? gbn_arq_pkg::ST_ACK : gbn_arq_pkg::ST_DATA;
            end
            gbn_arq_pkg::FUNC_TICK: begin
              tick_nxt = tick_r + TW'(1);
              st_nxt   = gbn_arq_pkg::ST_TICK;
            end
            default: st_nxt = gbn_arq_pkg::ST_IDLE;
          endcase
        end
      end
      gbn_arq_pkg::ST_SEND: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b1;
          if (outstanding < LIMIT_SEQ) begin
            out_kind_nxt  = gbn_arq_pkg::KIND_DATA;
            out_seq_nxt   = SW'(next_r);
            out_pay_nxt   = PW'(pay_r);
            pay_we        = 1'b1;
            stamp_we      = 1'b1;
            wr_slot       = next_slot_r;
            next_nxt      = adv_seq_out;
            next_slot_nxt = adv_slot_out;
          end else begin
            out_kind_nxt = gbn_arq_pkg::KIND_REFUSE;
            out_seq_nxt  = '0;
            out_pay_nxt  = '0;
          end
          st_nxt = gbn_arq_pkg::ST_IDLE;
        end
      end
      gbn_arq_pkg::ST_DATA: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b1;
          out_kind_nxt  = gbn_arq_pkg::KIND_ACK;
          out_pay_nxt   = '0;
          if (seq_r == exp_r) begin
            out_seq_nxt = SW'(exp_r);
            exp_nxt     = exp_r + SEQ_BITS'(1);
          end else begin
            out_seq_nxt = SW'(exp_r - SEQ_BITS'(1));
          end
          st_nxt = gbn_arq_pkg::ST_IDLE;
        end
      end
      gbn_arq_pkg::ST_ACK: begin
        if ((seq_r - base_r) < outstanding) begin
          st_nxt = gbn_arq_pkg::ST_WALK;
        end else begin
          st_nxt = gbn_arq_pkg::ST_IDLE;
        end
      end
      gbn_arq_pkg::ST_WALK: begin
        base_nxt      = adv_seq_out;
        base_slot_nxt = adv_slot_out;
        if (adv_seq_out == seq_r + SEQ_BITS'(1)) begin
          st_nxt = gbn_arq_pkg::ST_IDLE;
        end
      end
      gbn_arq_pkg::ST_TICK: begin
        cur_nxt      = base_r;
        cur_slot_nxt = base_slot_r;
        rem_nxt      = CNT_BITS'(outstanding);
        st_nxt       = (outstanding == '0) ? gbn_arq_pkg::ST_IDLE : gbn_arq_pkg::ST_SCAN_RD;
      end
      gbn_arq_pkg::ST_SCAN_RD: begin
        st_nxt = gbn_arq_pkg::ST_SCAN_CHK;
      end
      gbn_arq_pkg::ST_SCAN_CHK: begin
        if (expired) begin
          cur_nxt      = base_r;
          cur_slot_nxt = base_slot_r;
          rem_nxt      = CNT_BITS'(outstanding);
          st_nxt       = gbn_arq_pkg::ST_RS_RD;
        end else if (rem_r == CNT_BITS'(1)) begin
          st_nxt = gbn_arq_pkg::ST_IDLE;
        end else begin
          cur_nxt      = adv_seq_out;
          cur_slot_nxt = adv_slot_out;
          rem_nxt      = rem_r - CNT_BITS'(1);
          st_nxt       = gbn_arq_pkg::ST_SCAN_RD;
        end
      end
      gbn_arq_pkg::ST_RS_RD: begin
        st_nxt = gbn_arq_pkg::ST_RS_EMIT;
      end
      gbn_arq_pkg::ST_RS_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = gbn_arq_pkg::KIND_DATA;
          out_seq_nxt   = SW'(cur_r);
          out_pay_nxt   = PW'(pay_rd_r);
          out_last_nxt  = (rem_r == CNT_BITS'(1));
          stamp_we      = 1'b1;
          wr_slot       = cur_slot_r;
          cur_nxt       = adv_seq_out;
          cur_slot_nxt  = adv_slot_out;
          rem_nxt       = rem_r - CNT_BITS'(1);
          st_nxt        = (rem_r == CNT_BITS'(1)) ? gbn_arq_pkg::ST_IDLE
                                                  : gbn_arq_pkg::ST_RS_RD;
        end
      end
      default: st_nxt = gbn_arq_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= gbn_arq_pkg::ST_IDLE;
      base_r      <= '0;
      base_slot_r <= '0;
      next_r      <= '0;
      next_slot_r <= '0;
      exp_r       <= '0;
      tick_r      <= '0;
      timeout_r   <= gbn_arq_pkg::TIMEOUT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      base_r      <= base_nxt;
      base_slot_r <= base_slot_nxt;
      next_r      <= next_nxt;
      next_slot_r <= next_slot_nxt;
      exp_r       <= exp_nxt;
      tick_r      <= tick_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        timeout_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r       <= cur_nxt;
    cur_slot_r  <= cur_slot_nxt;
    rem_r       <= rem_nxt;
    seq_r       <= seq_nxt;
    pay_r       <= pay_nxt;
    out_kind_r  <= out_kind_nxt;
    out_seq_r   <= out_seq_nxt;
    out_pay_r   <= out_pay_nxt;
    out_last_r  <= out_last_nxt;
  end

  // slot memories, one registered read port at the cursor
  always_ff @(posedge clk) begin
    if (pay_we) begin
      pay_mem[wr_slot] <= pay_r;
    end
    if (stamp_we) begin
      stamp_mem[wr_slot] <= tick_r;
    end
    pay_rd_r   <= pay_mem[cur_slot_r];
    stamp_rd_r <= stamp_mem[cur_slot_r];
  end

  assign cfg_ready   = 1'b1;
  assign out_valid   = out_valid_r;
  assign out_kind    = out_kind_r;
  assign out_seq     = out_seq_r;
  assign out_payload = out_pay_r;
  assign out_last    = out_last_r;

  `GBN_ASSERT_NOW(a_window_bound, 1'b1, outstanding <= LIMIT_SEQ, "window over limit")
  `GBN_ASSERT_NOW(a_walk_inside, st_r == gbn_arq_pkg::ST_WALK, outstanding != '0, "ack walk past next")
  `GBN_ASSERT_NEXT(a_tick_hold, st_r != gbn_arq_pkg::ST_IDLE, $stable(tick_r), "tick moved mid item")
  `GBN_ASSERT_NEXT(a_send_step, st_r == gbn_arq_pkg::ST_SEND && out_free && outstanding < LIMIT_SEQ, next_r == $past(next_r) + SEQ_BITS'(1), "send did not advance next")

endmodule

### tb/sv/tb_go_back_n_arq_endpoint_top.sv
// self-checking testbench for go_back_n_arq_endpoint_top: sender window, receiver acks,
// tick driven resend, checked against an in-bench prediction of every result item
// depends on gbn_arq_pkg and the rtl of go_back_n_arq_endpoint_top
module tb_go_back_n_arq_endpoint_top;

  localparam int WIN           = gbn_arq_pkg::DEF_WINDOW_DEPTH;
  localparam int SW            = gbn_arq_pkg::SEQ_PORT_W;
  localparam int PW            = gbn_arq_pkg::PAY_PORT_W;
  localparam int TW            = gbn_arq_pkg::TICK_W;
  localparam int OW            = gbn_arq_pkg::TIMEOUT_W;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 150;

  typedef struct packed {
    gbn_arq_pkg::kind_t kind;
    logic [SW-1:0]      seq;
    logic [PW-1:0]      payload;
    logic               last;
  } pkt_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_ready;
  logic [1:0]    in_func = gbn_arq_pkg::FUNC_SEND;
  logic [SW-1:0] in_seq = '0;
  logic          in_is_ack = 1'b0;
  logic [PW-1:0] in_payload = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  logic [1:0]    out_kind;
  logic [SW-1:0] out_seq;
  logic [PW-1:0] out_payload;
  logic          out_last;
  logic          cfg_valid = 1'b0;
  logic          cfg_ready;
  logic [OW-1:0] cfg_data = '0;

  // predicted endpoint state
  logic [OW-1:0] timeout_q = gbn_arq_pkg::TIMEOUT_RESET;
  logic [SW-1:0] base_q = '0;
  logic [SW-1:0] next_q = '0;
  logic [SW-1:0] expect_q = '0;
  logic [TW-1:0] clock_q = '0;
  logic [PW-1:0] slot_pay [WIN];
  logic [TW-1:0] slot_stamp [WIN];

  pkt_t pending [$];
  int   mismatches = 0;
  int   cycles = 0;
  bit   calm = 1'b0;
  int   hold_req = 0;
  int   hold_seen = 0;
  int   hold_left = 0;
  int   idle_left = 0;
  pkt_t got;
  pkt_t want;

  go_back_n_arq_endpoint_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_func    (in_func),
    .in_seq     (in_seq),
    .in_is_ack  (in_is_ack),
    .in_payload (in_payload),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_kind   (out_kind),
    .out_seq    (out_seq),
    .out_payload(out_payload),
    .out_last   (out_last),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic pkt_t mk_pkt(gbn_arq_pkg::kind_t k, logic [SW-1:0] s,
                                  logic [PW-1:0] p);
    pkt_t r;
    r.kind = k;
    r.seq = s;
    r.payload = p;
    r.last = 1'b0;
    return r;
  endfunction

  // expected packets for one accepted item, updates the predicted state
  task automatic arq_predict(gbn_arq_pkg::func_t f, logic [SW-1:0] seq, logic ack,
                             logic [PW-1:0] pay);
    logic [SW-1:0] outs;
    logic [SW-1:0] gap;
    logic [SW-1:0] q;
    logic [TW-1:0] age;
    bit            expired;
    pkt_t          pkts [WIN];
    int            n;
    n = 0;
    expired = 1'b0;
    outs = next_q - base_q;
    case (f)
      gbn_arq_pkg::FUNC_SEND: begin
        if (outs < WIN) begin
          slot_pay[int'(next_q) % WIN] = pay;
          slot_stamp[int'(next_q) % WIN] = clock_q;
          pkts[n] = mk_pkt(gbn_arq_pkg::KIND_DATA, next_q, pay);
          n++;
          next_q = next_q + 1'b1;
        end else begin
          pkts[n] = mk_pkt(gbn_arq_pkg::KIND_REFUSE, '0, '0);
          n++;
        end
      end
      gbn_arq_pkg::FUNC_LINK: begin
        if (ack) begin
          gap = seq - base_q;
          if (gap < outs) base_q = seq + 1'b1;
        end else if (seq == expect_q) begin
          pkts[n] = mk_pkt(gbn_arq_pkg::KIND_ACK, seq, '0);
          n++;
          expect_q = expect_q + 1'b1;
        end else begin
          pkts[n] = mk_pkt(gbn_arq_pkg::KIND_ACK, expect_q - 1'b1, '0);
          n++;
        end
      end
      gbn_arq_pkg::FUNC_TICK: begin
        clock_q = clock_q + 1'b1;
        for (int i = 0; i < int'(outs); i++) begin
          q = base_q + 16'(i);
          age = clock_q - slot_stamp[int'(q) % WIN];
          if (age >= TW'(timeout_q)) expired = 1'b1;
        end
        if (expired) begin
          for (int i = 0; i < int'(outs); i++) begin
            q = base_q + 16'(i);
            slot_stamp[int'(q) % WIN] = clock_q;
            pkts[n] = mk_pkt(gbn_arq_pkg::KIND_DATA, q, slot_pay[int'(q) % WIN]);
            n++;
          end
        end
      end
      default: ;
    endcase
    if (n > 0) pkts[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) pending.push_back(pkts[i]);
  endtask

  task automatic send_item(gbn_arq_pkg::func_t f, logic [SW-1:0] seq, logic ack,
                           logic [PW-1:0] pay);
    in_valid <= 1'b1;
    in_func <= f;
    in_seq <= seq;
    in_is_ack <= ack;
    in_payload <= pay;
    do @(posedge clk); while (!in_ready);
    arq_predict(f, seq, ack, pay);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_timeout(logic [OW-1:0] v);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    timeout_q = v;
  endtask

  task automatic rand_item();
    int            pick;
    logic [SW-1:0] s;
    logic [SW-1:0] outs;
    logic [PW-1:0] p;
    pick = $urandom_range(0, 99);
    outs = next_q - base_q;
    p = $urandom();
    case ($urandom_range(0, 9))
      0: p = '0;
      1: p = '1;
      default: ;
    endcase
    if (pick < 35) begin
      send_item(gbn_arq_pkg::FUNC_SEND, 16'($urandom()), 1'($urandom()), p);
    end else if (pick < 55) begin
      // mostly acks inside the outstanding range
      if (outs != 0 && $urandom_range(0, 4) != 0) s = base_q + 16'($urandom_range(0, outs - 1));
      else s = 16'($urandom());
      send_item(gbn_arq_pkg::FUNC_LINK, s, 1'b1, p);
    end else if (pick < 75) begin
      if ($urandom_range(0, 3) != 0) s = expect_q;
      else s = 16'($urandom());
      send_item(gbn_arq_pkg::FUNC_LINK, s, 1'b0, p);
    end else if (pick < 95) begin
      send_item(gbn_arq_pkg::FUNC_TICK, 16'($urandom()), 1'($urandom()), p);
    end else begin
      send_item(gbn_arq_pkg::FUNC_NONE, 16'($urandom()), 1'($urandom()), p);
    end
  endtask

  task automatic test_receiver_side();
    send_item(gbn_arq_pkg::FUNC_TICK, 16'hFFFF, 1'b1, 32'hFFFF_FFFF);
    // out of order with nothing received yet re-acks the wrapped number
    send_item(gbn_arq_pkg::FUNC_LINK, 16'h0005, 1'b0, 32'h0);
    send_item(gbn_arq_pkg::FUNC_LINK, 16'h0000, 1'b0, 32'h0);
    send_item(gbn_arq_pkg::FUNC_LINK, 16'hFFFF, 1'b0, 32'hFFFF_FFFF);
    send_item(gbn_arq_pkg::FUNC_LINK, 16'h0001, 1'b0, 32'h0);
    send_item(gbn_arq_pkg::FUNC_NONE, 16'hFFFF, 1'b1, 32'hFFFF_FFFF);
  endtask

  task automatic test_window_full();
    send_item(gbn_arq_pkg::FUNC_SEND, 16'h0, 1'b0, 32'h0);
    send_item(gbn_arq_pkg::FUNC_SEND, 16'hFFFF, 1'b1, 32'hFFFF_FFFF);
    repeat (WIN - 2) send_item(gbn_arq_pkg::FUNC_SEND, 16'($urandom()), 1'b0, $urandom());
    send_item(gbn_arq_pkg::FUNC_SEND, 16'h0, 1'b0, 32'hA5A5_5A5A);
    // ack of the next number and ack behind the base are ignored
    send_item(gbn_arq_pkg::FUNC_LINK, next_q, 1'b1, 32'h0);
    send_item(gbn_arq_pkg::FUNC_LINK, 16'hFFFF, 1'b1, 32'h0);
    send_item(gbn_arq_pkg::FUNC_LINK, base_q + 16'd2, 1'b1, 32'h0);
    send_item(gbn_arq_pkg::FUNC_SEND, 16'h0, 1'b0, $urandom());
  endtask

  task automatic test_timeout_resend();
    write_timeout(8'd1);
    send_item(gbn_arq_pkg::FUNC_TICK, 16'h0, 1'b0, 32'h0);
    send_item(gbn_arq_pkg::FUNC_LINK, next_q - 1'b1, 1'b1, 32'h0);
    send_item(gbn_arq_pkg::FUNC_TICK, 16'h0, 1'b0, 32'h0);
  endtask

  task automatic test_zero_timeout();
    write_timeout(8'd0);
    send_item(gbn_arq_pkg::FUNC_SEND, 16'h0, 1'b0, $urandom());
    send_item(gbn_arq_pkg::FUNC_TICK, 16'h0, 1'b0, 32'h0);
    send_item(gbn_arq_pkg::FUNC_TICK, 16'h0, 1'b0, 32'h0);
    send_item(gbn_arq_pkg::FUNC_LINK, base_q, 1'b1, 32'h0);
  endtask

  task automatic test_backpressure();
    write_timeout(8'd255);
    send_item(gbn_arq_pkg::FUNC_TICK, 16'h0, 1'b0, 32'h0);
    hold_req++;
    for (int i = 0; i < 14; i++) begin
      if (i % 2 == 0) send_item(gbn_arq_pkg::FUNC_SEND, 16'h0, 1'b0, $urandom());
      else send_item(gbn_arq_pkg::FUNC_LINK, expect_q, 1'b0, $urandom());
    end
    wait_idle();
  endtask

  task automatic test_random(logic [OW-1:0] tmo, int count);
    write_timeout(tmo);
    repeat (count) rand_item();
  endtask

  // result checker and receiver side ready
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      got.kind = gbn_arq_pkg::kind_t'(out_kind);
      got.seq = out_seq;
      got.payload = out_payload;
      got.last = out_last;
      if (pending.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected item: kind %0d seq %h payload %h last %b",
                   got.kind, got.seq, got.payload, got.last);
        mismatches++;
      end else begin
        want = pending.pop_front();
        if (got.kind !== want.kind || got.seq !== want.seq ||
            got.payload !== want.payload || got.last !== want.last) begin
          if (mismatches < 10)
            $display("mismatch: expected kind %0d seq %h payload %h last %b, %s",
                     want.kind, want.seq, want.payload, want.last,
                     $sformatf("got kind %0d seq %h payload %h last %b",
                               got.kind, got.seq, got.payload, got.last));
          mismatches++;
        end
      end
    end
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (idle_left > 0) begin
      idle_left--;
      out_ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 3) == 0) begin
      idle_left = $urandom_range(0, 3);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_receiver_side();
    test_window_full();
    test_timeout_resend();
    test_zero_timeout();
    test_backpressure();
    test_random(8'd3, 50);
    test_random(8'd0, 25);
    test_random(8'd255, 35);
    calm = 1'b1;
    test_random(8'($urandom_range(1, 8)), 60);
    wait_idle();
    if (mismatches == 0 && pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
